[design/rbws_pkg.sv]
// Package for the ring buffer window statistics block.
// Field widths, status and operation codes, and the divider status type.
// No dependencies.
package rbws_pkg;

   // field widths of one reading and of the report
   localparam int TEMP_W   = 15;
   localparam int HUM_W    = 14;
   localparam int PRES_W   = 17;
   localparam int COUNT_W  = 9;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = TEMP_W + HUM_W + PRES_W;

   // sums over at most 2**COUNT_W - 1 readings
   localparam int TSUM_W = TEMP_W + COUNT_W;
   localparam int HSUM_W = HUM_W + COUNT_W;
   localparam int PSUM_W = PRES_W + COUNT_W;

   // dividend width of the shared divider (widest sum magnitude)
   localparam int DIV_W = PSUM_W;

   // operation codes
   localparam logic OP_STORE  = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_STORED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REPORT  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_DATA = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[design/rbws_divider.sv]
// Shared iterative divider: unsigned dividend by a count, one quotient bit per cycle.
// Depends on rbws_pkg.
module rbws_divider (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [rbws_pkg::DIV_W-1:0]            dividend,
   input  logic [rbws_pkg::COUNT_W-1:0]          divisor,
   output logic [rbws_pkg::DIV_W-1:0]            quotient,
   output rbws_pkg::div_status_type              status
);

   localparam int STEP_W = $clog2(rbws_pkg::DIV_W + 1);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(rbws_pkg::DIV_W - 1);

   logic                              busy_ff;
   logic                              done_ff;
   logic [STEP_W-1:0]                 step_ff;
   logic [rbws_pkg::COUNT_W:0]        rem_ff;
   logic [rbws_pkg::COUNT_W:0]        rem_in;
   logic [rbws_pkg::DIV_W-1:0]        dq_ff;
   logic [rbws_pkg::DIV_W-1:0]        dq_in;
   logic [rbws_pkg::COUNT_W-1:0]      divisor_ff;
   logic [rbws_pkg::COUNT_W:0]        rem_shift;
   logic [rbws_pkg::COUNT_W:0]        rem_diff;
   logic                              fits;

   // one restoring step: bring down the next dividend bit, try a subtract
   always_comb begin
      rem_shift = {rem_ff[rbws_pkg::COUNT_W-1:0], dq_ff[rbws_pkg::DIV_W-1]};
      rem_diff  = rem_shift - {1'b0, divisor_ff};
      fits      = (rem_shift >= {1'b0, divisor_ff});
      rem_in    = fits ? rem_diff : rem_shift;
      dq_in     = {dq_ff[rbws_pkg::DIV_W-2:0], fits};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath: partial remainder and dividend shifting into quotient
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= '0;
         dq_ff      <= dividend;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dq_ff  <= dq_in;
      end
   end

   assign quotient    = dq_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[design/rbws_ring.sv]
// Reading ring storage: one write port and one registered read port.
// Depends on rbws_pkg.
module rbws_ring #(
   parameter int RING_DEPTH = 256,
   parameter int PTR_W      = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [PTR_W-1:0]                  wr_addr,
   input  logic [rbws_pkg::ENTRY_W-1:0]      wr_data,
   input  logic                              rd_en,
   input  logic [PTR_W-1:0]                  rd_addr,
   output logic [rbws_pkg::ENTRY_W-1:0]      rd_data,
   output logic                              rd_valid
);

   logic [rbws_pkg::ENTRY_W-1:0] mem_ff [RING_DEPTH];
   logic [rbws_pkg::ENTRY_W-1:0] rd_data_ff;
   logic                         rd_valid_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // read data valid in the cycle after the read
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

[design/ring_buffer_window_statistics.sv]
// Ring buffer window statistics: keeps the RING_DEPTH newest sensor readings and reports
// mean, minimum and maximum of temperature, humidity and pressure over the newest N.
// Depends on rbws_pkg, rbws_ring and rbws_divider.
//
// A store request is answered through the response register, ready the next cycle. A report
// request with a zero count or an empty ring answers the same way with no-data status.
// Otherwise a report reads the ring one entry per cycle through its single read port,
// then runs the three means through one shared divider at one quotient bit per cycle.
// One request is in work at a time; req_stall stays high until the response register
// is free and the block is idle. The ring has no reset; only written entries are read.
module ring_buffer_window_statistics #(
   parameter int RING_DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_operation,
   input  logic signed [rbws_pkg::TEMP_W-1:0]   req_temperature_in,
   input  logic [rbws_pkg::HUM_W-1:0]           req_humidity_in,
   input  logic [rbws_pkg::PRES_W-1:0]          req_pressure_in,
   input  logic [rbws_pkg::COUNT_W-1:0]         req_requested_count,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rbws_pkg::STATUS_W-1:0]        rsp_status,
   output logic [rbws_pkg::COUNT_W-1:0]         rsp_used_count,
   output logic [rbws_pkg::COUNT_W-1:0]         rsp_stored_count_out,
   output logic signed [rbws_pkg::TEMP_W-1:0]   rsp_temperature_mean,
   output logic signed [rbws_pkg::TEMP_W-1:0]   rsp_temperature_min,
   output logic signed [rbws_pkg::TEMP_W-1:0]   rsp_temperature_max,
   output logic [rbws_pkg::HUM_W-1:0]           rsp_humidity_mean,
   output logic [rbws_pkg::HUM_W-1:0]           rsp_humidity_min,
   output logic [rbws_pkg::HUM_W-1:0]           rsp_humidity_max,
   output logic [rbws_pkg::PRES_W-1:0]          rsp_pressure_mean,
   output logic [rbws_pkg::PRES_W-1:0]          rsp_pressure_min,
   output logic [rbws_pkg::PRES_W-1:0]          rsp_pressure_max
);

   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int CMP_W = (CNT_W > rbws_pkg::COUNT_W) ? CNT_W : rbws_pkg::COUNT_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
   localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(RING_DEPTH);

   localparam int TW = rbws_pkg::TEMP_W;
   localparam int HW = rbws_pkg::HUM_W;
   localparam int PW = rbws_pkg::PRES_W;
   localparam int CW = rbws_pkg::COUNT_W;

   // sequencer states
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_WALK      = 3'd1;
   localparam logic [2:0] ST_DIV_START = 3'd2;
   localparam logic [2:0] ST_DIV_WAIT  = 3'd3;
   localparam logic [2:0] ST_DONE      = 3'd4;

   // divider operand select
   localparam logic [1:0] DIV_TEMP = 2'd0;
   localparam logic [1:0] DIV_HUM  = 2'd1;
   localparam logic [1:0] DIV_PRES = 2'd2;

   logic [2:0]                          state_ff;
   logic [2:0]                          state_in;
   logic [PTR_W-1:0]                    wp_ff;
   logic [PTR_W-1:0]                    wp_in;
   logic [CNT_W-1:0]                    fill_ff;
   logic [CNT_W-1:0]                    fill_in;
   logic [PTR_W-1:0]                    addr_ff;
   logic [CW-1:0]                       left_ff;
   logic [CW-1:0]                       used_ff;
   logic                                first_ff;
   logic [1:0]                          div_sel_ff;

   logic signed [rbws_pkg::TSUM_W-1:0]  tsum_ff;
   logic [rbws_pkg::HSUM_W-1:0]         hsum_ff;
   logic [rbws_pkg::PSUM_W-1:0]         psum_ff;
   logic signed [TW-1:0]                tmin_ff;
   logic signed [TW-1:0]                tmax_ff;
   logic [HW-1:0]                       hmin_ff;
   logic [HW-1:0]                       hmax_ff;
   logic [PW-1:0]                       pmin_ff;
   logic [PW-1:0]                       pmax_ff;
   logic signed [TW-1:0]                tmean_ff;
   logic [HW-1:0]                       hmean_ff;
   logic [PW-1:0]                       pmean_ff;

   logic                                rsp_valid_ff;
   logic [rbws_pkg::STATUS_W-1:0]       status_ff;
   logic [rbws_pkg::STATUS_W-1:0]       status_in;
   logic [CW-1:0]                       used_out_ff;
   logic [CW-1:0]                       used_out_in;
   logic [CW-1:0]                       stored_ff;
   logic [CW-1:0]                       stored_in;
   logic                                stats_zero_ff;

   logic                                out_free;
   logic                                req_accept;
   logic                                do_store;
   logic                                do_report;
   logic                                load_direct;
   logic                                load_report;
   logic [CMP_W-1:0]                    req_ext;
   logic [CMP_W-1:0]                    fill_ext;
   logic [CMP_W-1:0]                    fill_in_ext;
   logic [CMP_W-1:0]                    used_ext;
   logic [CW-1:0]                       used_now;
   logic [PTR_W-1:0]                    addr_start;

   logic                                rd_en;
   logic [rbws_pkg::ENTRY_W-1:0]        rd_data;
   logic                                rd_valid;
   logic signed [TW-1:0]                rd_temp;
   logic [HW-1:0]                       rd_hum;
   logic [PW-1:0]                       rd_pres;

   logic                                div_start;
   logic [rbws_pkg::DIV_W-1:0]          div_dividend;
   logic [rbws_pkg::DIV_W-1:0]          div_quotient;
   rbws_pkg::div_status_type            div_status;
   logic                                tsum_neg;
   logic [rbws_pkg::TSUM_W-1:0]         tsum_mag;
   logic [TW-1:0]                       tq;

   // handshake
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) && out_free);
   assign req_accept = req_valid && !req_stall;
   assign do_store   = req_accept && (req_operation == rbws_pkg::OP_STORE);
   assign do_report  = req_accept && (req_operation == rbws_pkg::OP_REPORT);

   // pointer and fill updates on a store
   always_comb begin
      wp_in      = (wp_ff == PTR_LAST) ? '0 : wp_ff + 1'b1;
      fill_in    = (fill_ff == FILL_FULL) ? fill_ff : fill_ff + 1'b1;
      addr_start = (wp_ff == '0) ? PTR_LAST : wp_ff - 1'b1;
   end

   // clamp the requested count to the readings held
   always_comb begin
      req_ext     = CMP_W'(req_requested_count);
      fill_ext    = CMP_W'(fill_ff);
      fill_in_ext = CMP_W'(fill_in);
      used_ext    = (req_ext > fill_ext) ? fill_ext : req_ext;
      used_now    = used_ext[CW-1:0];
   end

   assign load_direct = do_store || (do_report && (used_now == '0));
   assign load_report = (state_ff == ST_DONE) && out_free;

   // ring storage
   assign rd_en = (state_ff == ST_WALK) && (left_ff != '0);

   rbws_ring #(
      .RING_DEPTH (RING_DEPTH),
      .PTR_W      (PTR_W)
   ) u_ring (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (do_store),
      .wr_addr  (wp_ff),
      .wr_data  ({req_temperature_in, req_humidity_in, req_pressure_in}),
      .rd_en    (rd_en),
      .rd_addr  (addr_ff),
      .rd_data  (rd_data),
      .rd_valid (rd_valid)
   );

   assign rd_temp = $signed(rd_data[rbws_pkg::ENTRY_W-1 -: TW]);
   assign rd_hum  = rd_data[PW +: HW];
   assign rd_pres = rd_data[PW-1:0];

   // shared divider operand select
   assign tsum_neg = tsum_ff[rbws_pkg::TSUM_W-1];
   assign tsum_mag = tsum_neg ? $unsigned(-tsum_ff) : $unsigned(tsum_ff);

   always_comb begin
      case (div_sel_ff)
         DIV_TEMP: div_dividend = rbws_pkg::DIV_W'(tsum_mag);
         DIV_HUM:  div_dividend = rbws_pkg::DIV_W'(hsum_ff);
         DIV_PRES: div_dividend = rbws_pkg::DIV_W'(psum_ff);
         default:  div_dividend = '0;
      endcase
   end

   assign div_start = (state_ff == ST_DIV_START) && !div_status.busy;
   assign tq        = div_quotient[TW-1:0];

   rbws_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (used_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (do_report && (used_now != '0)) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if ((left_ff == '0) && !rd_valid) begin
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            if (div_start) begin
               state_in = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               state_in = (div_sel_ff == DIV_PRES) ? ST_DONE : ST_DIV_START;
            end
         end
         ST_DONE: begin
            if (load_report) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wp_ff      <= '0;
         fill_ff    <= '0;
         left_ff    <= '0;
         div_sel_ff <= DIV_TEMP;
      end else begin
         state_ff <= state_in;
         if (do_store) begin
            wp_ff   <= wp_in;
            fill_ff <= fill_in;
         end
         if (do_report) begin
            left_ff <= used_now;
         end else if (rd_en) begin
            left_ff <= left_ff - 1'b1;
         end
         if (do_report) begin
            div_sel_ff <= DIV_TEMP;
         end else if ((state_ff == ST_DIV_WAIT) && div_status.done) begin
            div_sel_ff <= div_sel_ff + 1'b1;
         end
      end
   end

   // walk address, newest first, and accumulation of each read entry
   always_ff @(posedge clock) begin
      if (do_report) begin
         addr_ff  <= addr_start;
         used_ff  <= used_now;
         first_ff <= 1'b1;
         tsum_ff  <= '0;
         hsum_ff  <= '0;
         psum_ff  <= '0;
      end else begin
         if (rd_en) begin
            addr_ff <= (addr_ff == '0) ? PTR_LAST : addr_ff - 1'b1;
         end
         if (rd_valid) begin
            first_ff <= 1'b0;
            tsum_ff  <= tsum_ff + rbws_pkg::TSUM_W'(rd_temp);
            hsum_ff  <= hsum_ff + rbws_pkg::HSUM_W'(rd_hum);
            psum_ff  <= psum_ff + rbws_pkg::PSUM_W'(rd_pres);
            if (first_ff || (rd_temp < tmin_ff)) tmin_ff <= rd_temp;
            if (first_ff || (rd_temp > tmax_ff)) tmax_ff <= rd_temp;
            if (first_ff || (rd_hum < hmin_ff))  hmin_ff <= rd_hum;
            if (first_ff || (rd_hum > hmax_ff))  hmax_ff <= rd_hum;
            if (first_ff || (rd_pres < pmin_ff)) pmin_ff <= rd_pres;
            if (first_ff || (rd_pres > pmax_ff)) pmax_ff <= rd_pres;
         end
      end
   end

   // capture each mean as the divider finishes
   always_ff @(posedge clock) begin
      if ((state_ff == ST_DIV_WAIT) && div_status.done) begin
         case (div_sel_ff)
            DIV_TEMP: tmean_ff <= tsum_neg ? $signed(-tq) : $signed(tq);
            DIV_HUM:  hmean_ff <= div_quotient[HW-1:0];
            DIV_PRES: pmean_ff <= div_quotient[PW-1:0];
            default:  pmean_ff <= pmean_ff;
         endcase
      end
   end

   // response contents
   always_comb begin
      if (load_report) begin
         status_in   = rbws_pkg::STATUS_REPORT;
         used_out_in = used_ff;
         stored_in   = fill_ext[CW-1:0];
      end else if (do_store) begin
         status_in   = rbws_pkg::STATUS_STORED;
         used_out_in = '0;
         stored_in   = fill_in_ext[CW-1:0];
      end else begin
         status_in   = rbws_pkg::STATUS_NO_DATA;
         used_out_in = '0;
         stored_in   = fill_ext[CW-1:0];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_direct || load_report) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_direct || load_report) begin
         status_ff     <= status_in;
         used_out_ff   <= used_out_in;
         stored_ff     <= stored_in;
         stats_zero_ff <= !load_report;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_used_count       = used_out_ff;
   assign rsp_stored_count_out = stored_ff;
   assign rsp_temperature_mean = stats_zero_ff ? '0 : tmean_ff;
   assign rsp_temperature_min  = stats_zero_ff ? '0 : tmin_ff;
   assign rsp_temperature_max  = stats_zero_ff ? '0 : tmax_ff;
   assign rsp_humidity_mean    = stats_zero_ff ? '0 : hmean_ff;
   assign rsp_humidity_min     = stats_zero_ff ? '0 : hmin_ff;
   assign rsp_humidity_max     = stats_zero_ff ? '0 : hmax_ff;
   assign rsp_pressure_mean    = stats_zero_ff ? '0 : pmean_ff;
   assign rsp_pressure_min     = stats_zero_ff ? '0 : pmin_ff;
   assign rsp_pressure_max     = stats_zero_ff ? '0 : pmax_ff;

endmodule
